### rtl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the integer-to-decimal converter
// Holds the field widths, character codes, the controller state type and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package s2d_pkg;

   // Field widths.
   localparam int ValueWidth = 32;
   localparam int CharWidth  = 8;

   // Decimal digit store: ten BCD digits cover the full 32-bit magnitude.
   localparam int NumDigits  = 10;
   localparam int DigitWidth = 4;
   localparam int BcdWidth   = NumDigits * DigitWidth;
   localparam int CountWidth = $clog2(NumDigits + 1);
   localparam int StepWidth  = $clog2(ValueWidth);

   // Character codes.
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;
   localparam logic [CharWidth-1:0] CharZero  = 8'd48;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a request and form its magnitude
      logic shift_bin;   // one double-dabble step
      logic shift_dig;   // drop the top BCD digit
      logic emit_sign;   // put a minus sign into the output register
      logic emit_digit;  // put the top digit into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conv_last;   // the current conversion step is the final one
      logic top_zero;    // the top BCD digit is zero
      logic left_one;    // only one digit remains
      logic neg;         // the captured value is negative
      logic out_free;    // the output register can take a character
   } status_type;

endpackage

### rtl/s2d_ctrl.sv
// ----------------------------------------------------------------------------
// s2d_ctrl: sequencing controller
// Walks each request through binary-to-BCD conversion, leading-zero removal,
// the optional minus sign and the digit characters.
// ----------------------------------------------------------------------------
module s2d_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  s2d_pkg::status_type   status,
   output s2d_pkg::cmd_type      cmd
);
   import s2d_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.conv_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!status.top_zero || status.left_one) begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.left_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CONVERT: begin
            cmd.shift_bin = 1'b1;
         end
         ST_SKIP: begin
            cmd.shift_dig = status.top_zero && !status.left_one;
         end
         ST_SIGN: begin
            cmd.emit_sign = status.out_free;
         end
         ST_EMIT: begin
            cmd.emit_digit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/s2d_dpath.sv
// ----------------------------------------------------------------------------
// s2d_dpath: conversion datapath
// Holds the magnitude, the BCD digit register with its add-3 correction, the
// step and digit counters, and the registered output character.
// ----------------------------------------------------------------------------
module s2d_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [s2d_pkg::ValueWidth-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [s2d_pkg::CharWidth-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   input  s2d_pkg::cmd_type              cmd,
   output s2d_pkg::status_type           status
);
   import s2d_pkg::*;

   logic [ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [BcdWidth-1:0]   bcd_adj;
   logic                  neg_ff, neg_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth-1:0] left_ff, left_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  valid_ff, valid_in;
   logic [DigitWidth-1:0] top_digit;

   assign top_digit = bcd_ff[BcdWidth-1 -: DigitWidth];

   // Add-3 correction on every digit that is five or more.
   always_comb begin
      logic [DigitWidth-1:0] digit;
      for (int i = 0; i < NumDigits; i++) begin
         digit = bcd_ff[i*DigitWidth +: DigitWidth];
         bcd_adj[i*DigitWidth +: DigitWidth] =
            (digit >= 4'd5) ? digit + 4'd3 : digit;
      end
   end

   // Working registers for conversion and digit walk.
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      left_in = left_ff;
      if (cmd.load) begin
         neg_in  = req_tdata[ValueWidth-1];
         bin_in  = req_tdata[ValueWidth-1] ? ('0 - req_tdata) : req_tdata;
         bcd_in  = '0;
         step_in = '0;
         left_in = CountWidth'(NumDigits);
      end else if (cmd.shift_bin) begin
         bcd_in  = {bcd_adj[BcdWidth-2:0], bin_ff[ValueWidth-1]};
         bin_in  = {bin_ff[ValueWidth-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end else if (cmd.shift_dig || cmd.emit_digit) begin
         bcd_in  = {bcd_ff[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      left_ff <= left_in;
   end

   // Output register: loaded by an emit, released when the sink takes it.
   always_comb begin
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (cmd.emit_sign) begin
         char_in  = CharMinus;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end else if (cmd.emit_digit) begin
         char_in  = CharZero + CharWidth'(top_digit);
         last_in  = (left_ff == CountWidth'(1));
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

   // Status toward the controller.
   assign status.conv_last = (step_ff == StepWidth'(ValueWidth - 1));
   assign status.top_zero  = (top_digit == '0);
   assign status.left_one  = (left_ff == CountWidth'(1));
   assign status.neg       = neg_ff;
   assign status.out_free  = !valid_ff || rsp_tready;

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// After a request is accepted, the datapath runs its 32-step double-dabble
// loop before the first character is ready.
// Each request goes through accept, 32 shifts, leading-zero walk, sign, digits;
// a new request is taken only after the last digit of the previous one is emitted.
// Reset: synchronous, active high; clears the controller and output valid.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal text
// Each request carries one integer; the response stream carries its decimal
// characters, most significant first, with tlast on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [s2d_pkg::ValueWidth-1:0] req_tdata,   // [31:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [s2d_pkg::CharWidth-1:0] rsp_tdata,   // [7:0] char_code
   output logic                          rsp_tlast
);
   import s2d_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller.
   s2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath.
   s2d_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for signed_int_to_decimal_ascii
// Streams signed 32-bit requests into the converter and checks every character
// of the response stream, including tlast, against decimal text worked out
// here. Both the request and the response side pause at random.
// ----------------------------------------------------------------------------
module testbench;
   import s2d_pkg::*;

   localparam int Radix       = 10;
   localparam int RandomItems = 189;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 60;

   // One expected character of the response stream.
   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 last;
   } char_item_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ValueWidth-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CharWidth-1:0]  rsp_tdata;
   logic                  rsp_tlast;

   logic [ValueWidth-1:0] pending_values[$];
   char_item_t            expected_text[$];
   logic                  req_taken      = 1'b0;
   logic                  rsp_taken      = 1'b0;
   int                    send_gap       = 0;
   int                    stall_left     = 0;
   int                    sent_count     = 0;
   int                    accepted_count = 0;
   int                    received_count = 0;
   int                    total_items    = 0;
   int                    idle_cycles    = 0;
   int                    error_count    = 0;

   signed_int_to_decimal_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Appends the decimal text of one request to the expected characters.
   function automatic void append_decimal_text(input logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] magnitude;
      logic [DigitWidth-1:0] digits [NumDigits];
      int                    count;
      magnitude = value[ValueWidth-1] ? (~value + 1'b1) : value;
      count = 0;
      do begin
         digits[count] = DigitWidth'(magnitude % Radix);
         magnitude = magnitude / Radix;
         count++;
      end while (magnitude != 0 && count < NumDigits);
      if (value[ValueWidth-1]) begin
         expected_text.push_back('{char_code: CharMinus, last: 1'b0});
      end
      for (int k = count - 1; k >= 0; k--) begin
         expected_text.push_back('{char_code: CharZero + CharWidth'(digits[k]),
                                   last: (k == 0)});
      end
   endfunction

   // Mostly no pause or a short one, now and then a long one; none at all when calm.
   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 15);
      if (calm || roll < 9) begin
         return 0;
      end else if (roll < 14) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 50);
      end
   endfunction

   // Request driver: presents queued values at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // Hold the current request until it is taken.
      end else if (send_gap > 0) begin
         send_gap   <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_values.size() != 0) begin
         req_tdata  <= pending_values.pop_front();
         req_tvalid <= 1'b1;
         send_gap   <= pick_gap((sent_count % 48) < 12);
         sent_count <= sent_count + 1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response sink: stalls at random between characters.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_taken) begin
            stall_left <= pick_gap((received_count % 64) < 16);
         end
      end
   end

   // Monitor: records accepted requests and checks each response character.
   always @(posedge clock) begin
      char_item_t want;
      req_taken <= req_tvalid && req_tready && !reset;
      rsp_taken <= rsp_tvalid && rsp_tready && !reset;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received_count <= received_count + 1;
         if (expected_text.size() == 0) begin
            $error("rsp: unexpected character, actual %0d", rsp_tdata);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.char_code) begin
               $error("char_code: expected %0d, actual %0d", want.char_code, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         append_decimal_text(req_tdata);
         accepted_count <= accepted_count + 1;
      end
   end

   // Watchdog: ends the run when neither side has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of test.
   initial begin
      int                    pow10 [NumDigits + 1];
      int                    edge_values[$];
      int                    kind;
      int                    width;
      logic [ValueWidth-1:0] magnitude;
      logic [ValueWidth-1:0] value;

      pow10[0] = 1;
      for (int k = 1; k < NumDigits; k++) begin
         pow10[k] = pow10[k-1] * Radix;
      end
      edge_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999999999,
                      1000000000, -1000000000, 2147483647, 32'h8000_0001,
                      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                      123456789, -123456789, 2000000000};

      // Directed part: bounds, zero, sign changes and digit-count steps.
      foreach (edge_values[k]) begin
         pending_values.push_back(edge_values[k]);
      end

      // Random part: mostly values of a random digit count, some full range.
      for (int n = 0; n < RandomItems; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            width     = $urandom_range(1, NumDigits - 1);
            magnitude = $urandom_range(0, pow10[width] - 1);
            value     = $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
         end else if (kind < 9) begin
            value = $urandom();
         end else begin
            value = edge_values[$urandom_range(0, edge_values.size() - 1)];
         end
         pending_values.push_back(value);
      end
      total_items = pending_values.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(negedge clock);
      while (expected_text.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/s2d_pkg.sv
rtl/s2d_ctrl.sv
rtl/s2d_dpath.sv
rtl/signed_int_to_decimal_ascii.sv
dv/testbench.sv
